// ===== sv/configurable_packet_framer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the packet framer
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef CONFIGURABLE_PACKET_FRAMER_UNIT_ASSERT_SVH
`define CONFIGURABLE_PACKET_FRAMER_UNIT_ASSERT_SVH

// antecedent and consequent in the same cycle
`define CPF_CHECK_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent in the cycle after the antecedent
`define CPF_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/cpf_pkg.sv =====
// ----------------------------------------------------------------------------
// cpf_pkg
// Types and constants shared by the packet framer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpf_pkg;

   localparam int CPF_MAX_PAYLOAD = 255;
   localparam int CPF_QUEUE_DEPTH = 2;

   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   localparam logic [1:0] CHECK_NONE  = 2'd0;
   localparam logic [1:0] CHECK_XOR   = 2'd1;
   localparam logic [1:0] CHECK_CONST = 2'd2;

   localparam logic [2:0] CSR_HEAD_BYTES   = 3'd0;
   localparam logic [2:0] CSR_ADDR_BYTES   = 3'd1;
   localparam logic [2:0] CSR_LENGTH_BYTES = 3'd2;
   localparam logic [2:0] CSR_ORDER_BYTES  = 3'd3;
   localparam logic [2:0] CSR_CHECK_MODE   = 3'd4;
   localparam logic [2:0] CSR_CHECK_VALUE  = 3'd5;

   localparam logic [1:0] FIELD_HEAD   = 2'd0;
   localparam logic [1:0] FIELD_ADDR   = 2'd1;
   localparam logic [1:0] FIELD_LENGTH = 2'd2;
   localparam logic [1:0] FIELD_ORDER  = 2'd3;

   typedef struct packed {
      logic [1:0] head_bytes;
      logic [1:0] addr_bytes;
      logic [1:0] length_bytes;
      logic [1:0] order_bytes;
      logic [1:0] check_mode;
      logic [7:0] check_value;
   } cfg_type;

   // one classified item on its way from front to back
   typedef struct packed {
      logic        is_header;
      logic        last;       // header: empty payload; payload: final byte
      logic [23:0] head_value;
      logic [23:0] addr_value;
      logic [7:0]  payload_len;
      logic [23:0] order_value;
      logic [7:0]  data_byte;
   } desc_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_HDR,
      BK_CHECK
   } back_state_type;

   typedef struct packed {
      logic idle;
      logic pop;
   } back_stat_type;

endpackage

// ===== sv/cpf_queue.sv =====
// ----------------------------------------------------------------------------
// cpf_queue
// Small flop queue of classified items between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpf_queue
   import cpf_pkg::*;
#(
   parameter int DEPTH = CPF_QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  desc_type                     wdata,
   output logic                         full,
   input  logic                         pop,
   output desc_type                     rdata,
   output logic                         valid,
   output logic [$clog2(DEPTH+1)-1:0]   level
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LvlW = $clog2(DEPTH + 1);

   desc_type            mem_ff [DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [LvlW-1:0]     level_ff, level_in;
   logic                do_push, do_pop;

   assign full    = (level_ff == LvlW'(DEPTH));
   assign valid   = (level_ff != '0);
   assign rdata   = mem_ff[rd_ptr_ff];
   assign level   = level_ff;
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + LvlW'(1);
      end else if (do_pop && !do_push) begin
         level_in = level_ff - LvlW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== sv/cpf_front.sv =====
// ----------------------------------------------------------------------------
// cpf_front
// Accepts input items, tracks the open packet and queues work for the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpf_front
   import cpf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // kind
   input  logic [87:0] req_tdata,   // head, addr, payload_len, order, data_byte
   input  logic        q_full,
   output logic        q_push,
   output desc_type    q_wdata
);

   localparam logic [16:0] MaxLen = 17'(CPF_MAX_PAYLOAD);

   logic       in_packet_ff, in_packet_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic       accept;
   logic [7:0] len_raw, len_sat;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;
   assign len_raw    = req_tdata[55:48];

   always_comb begin
      len_sat = len_raw;
      if ({9'd0, len_raw} > MaxLen) begin
         len_sat = MaxLen[7:0];
      end
   end

   always_comb begin
      in_packet_in          = in_packet_ff;
      bytes_left_in         = bytes_left_ff;
      q_push                = 1'b0;
      q_wdata.is_header     = (req_tuser == KIND_HEADER);
      q_wdata.last          = 1'b0;
      q_wdata.head_value    = req_tdata[23:0];
      q_wdata.addr_value    = req_tdata[47:24];
      q_wdata.payload_len   = len_sat;
      q_wdata.order_value   = req_tdata[79:56];
      q_wdata.data_byte     = req_tdata[87:80];
      if (accept) begin
         if (req_tuser == KIND_HEADER) begin
            // a new header abandons any open packet
            q_push        = 1'b1;
            q_wdata.last  = (len_sat == 8'd0);
            in_packet_in  = (len_sat != 8'd0);
            bytes_left_in = len_sat;
         end else if (in_packet_ff) begin
            q_push        = 1'b1;
            q_wdata.last  = (bytes_left_ff <= 8'd1);
            bytes_left_in = bytes_left_ff - 8'd1;
            if (bytes_left_ff <= 8'd1) begin
               in_packet_in  = 1'b0;
               bytes_left_in = 8'd0;
            end
         end
         // drop payload items that arrive outside a packet
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff  <= 1'b0;
         bytes_left_ff <= 8'd0;
      end else begin
         in_packet_ff  <= in_packet_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

endmodule

// ===== sv/cpf_back.sv =====
// ----------------------------------------------------------------------------
// cpf_back
// Serializes queued items onto the byte stream and appends the check byte in XOR or constant mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpf_back
   import cpf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  desc_type      q_rdata,
   input  logic          q_valid,
   output logic          q_pop,
   output back_stat_type stat,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata,   // out_byte
   output logic          rsp_tlast    // end_of_packet
);

   back_state_type state_ff, state_in;
   desc_type       hdr_ff, hdr_in;
   logic [1:0]     field_ff, field_in;
   logic [1:0]     byte_ff, byte_in;
   logic [3:0]     sent_ff, sent_in;
   logic [3:0]     total_ff, total_in;
   logic [7:0]     xor_ff, xor_in;
   logic           out_valid_ff, out_valid_in;
   logic [7:0]     out_byte_ff, out_byte_in;
   logic           out_last_ff, out_last_in;

   logic           out_free, check_on, hdr_done;
   logic           emit, emit_last;
   logic [7:0]     emit_byte;
   logic [3:0]     total;
   logic [1:0]     width_sel;
   logic [23:0]    value_sel;
   logic [7:0]     byte_sel;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign check_on   = (cfg.check_mode == CHECK_XOR) || (cfg.check_mode == CHECK_CONST);
   assign total      = {2'd0, cfg.head_bytes} + {2'd0, cfg.addr_bytes}
                     + {2'd0, cfg.length_bytes} + {2'd0, cfg.order_bytes};
   assign hdr_done   = ((sent_ff + 4'd1) == total_ff);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign stat.idle  = (state_ff == BK_IDLE);
   assign stat.pop   = q_pop;

   always_comb begin
      case (field_ff)
         FIELD_HEAD: begin
            width_sel = cfg.head_bytes;
            value_sel = hdr_ff.head_value;
         end
         FIELD_ADDR: begin
            width_sel = cfg.addr_bytes;
            value_sel = hdr_ff.addr_value;
         end
         FIELD_LENGTH: begin
            width_sel = cfg.length_bytes;
            value_sel = {16'd0, hdr_ff.payload_len};
         end
         FIELD_ORDER: begin
            width_sel = cfg.order_bytes;
            value_sel = hdr_ff.order_value;
         end
         default: begin
            width_sel = 2'd0;
            value_sel = 24'd0;
         end
      endcase
      case (byte_ff)
         2'd0:    byte_sel = value_sel[7:0];
         2'd1:    byte_sel = value_sel[15:8];
         2'd2:    byte_sel = value_sel[23:16];
         default: byte_sel = 8'd0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      hdr_in       = hdr_ff;
      field_in     = field_ff;
      byte_in      = byte_ff;
      sent_in      = sent_ff;
      total_in     = total_ff;
      xor_in       = xor_ff;
      q_pop        = 1'b0;
      emit         = 1'b0;
      emit_byte    = 8'd0;
      emit_last    = 1'b0;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         BK_IDLE: begin
            if (out_free && q_valid) begin
               q_pop = 1'b1;
               if (q_rdata.is_header) begin
                  hdr_in   = q_rdata;
                  xor_in   = 8'd0;
                  field_in = FIELD_HEAD;
                  byte_in  = 2'd0;
                  sent_in  = 4'd0;
                  total_in = total;
                  if (total != 4'd0) begin
                     state_in = BK_HDR;
                  end else if (q_rdata.last && check_on) begin
                     state_in = BK_CHECK;
                  end
               end else begin
                  emit      = 1'b1;
                  emit_byte = q_rdata.data_byte;
                  emit_last = q_rdata.last && !check_on;
                  if (q_rdata.last && check_on) begin
                     state_in = BK_CHECK;
                  end
               end
            end
         end
         BK_HDR: begin
            if (out_free) begin
               if (byte_ff < width_sel) begin
                  emit      = 1'b1;
                  emit_byte = byte_sel;
                  emit_last = hdr_done && hdr_ff.last && !check_on;
                  sent_in   = sent_ff + 4'd1;
                  byte_in   = byte_ff + 2'd1;
                  if (hdr_done) begin
                     state_in = (hdr_ff.last && check_on) ? BK_CHECK : BK_IDLE;
                  end
               end else begin
                  // advance past an exhausted or absent field
                  field_in = field_ff + 2'd1;
                  byte_in  = 2'd0;
               end
            end
         end
         BK_CHECK: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = (cfg.check_mode == CHECK_XOR) ? xor_ff : cfg.check_value;
               emit_last = 1'b1;
               state_in  = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         out_last_in  = emit_last;
         xor_in       = xor_ff ^ emit_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
         xor_ff       <= 8'd0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         xor_ff       <= xor_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff      <= hdr_in;
      field_ff    <= field_in;
      byte_ff     <= byte_in;
      sent_ff     <= sent_in;
      total_ff    <= total_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

endmodule

// ===== sv/configurable_packet_framer_unit.sv =====
// ----------------------------------------------------------------------------
// configurable_packet_framer_unit
// Packet framer: header fields, payload bytes and an optional check byte.
//
//   channel  dir  handshake            payload
//   req_     in   req_tvalid/tready    tuser kind, tdata header/payload fields
//   rsp_     out  rsp_tvalid/tready    tdata out_byte, tlast end_of_packet
//   csr_     in   csr_valid/ready      csr_index, csr_data
//
// A payload item leaves one byte per cycle while the output is not stalled. A
// header item is loaded, then puts out each header byte, steps past each field
// ahead of the last field that has bytes, and adds a check byte if it closes
// the packet and a check is on. The back sequencer and its one-byte output
// register set this rate. The front keeps accepting into the queue while it has
// room, also while the back is busy or stalled. Reset is synchronous; csr_ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "configurable_packet_framer_unit_assert.svh"

module configurable_packet_framer_unit
   import cpf_pkg::*;
#(
   parameter int QUEUE_DEPTH = CPF_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // kind
   input  logic [87:0] req_tdata,   // head_value, addr_value, payload_len,
                                    // order_value, data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tlast,   // end_of_packet
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);

   localparam int LvlW = $clog2(QUEUE_DEPTH + 1);

   cfg_type        cfg_ff, cfg_in;
   desc_type       q_wdata, q_rdata;
   logic           q_push, q_full, q_pop, q_valid;
   logic [LvlW-1:0] q_level;
   back_stat_type  bk_stat;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_HEAD_BYTES:   cfg_in.head_bytes   = csr_data[1:0];
            CSR_ADDR_BYTES:   cfg_in.addr_bytes   = csr_data[1:0];
            CSR_LENGTH_BYTES: cfg_in.length_bytes = csr_data[1:0];
            CSR_ORDER_BYTES:  cfg_in.order_bytes  = csr_data[1:0];
            CSR_CHECK_MODE:   cfg_in.check_mode   = csr_data[1:0];
            CSR_CHECK_VALUE:  cfg_in.check_value  = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head_bytes   <= 2'd1;
         cfg_ff.addr_bytes   <= 2'd1;
         cfg_ff.length_bytes <= 2'd1;
         cfg_ff.order_bytes  <= 2'd1;
         cfg_ff.check_mode   <= CHECK_NONE;
         cfg_ff.check_value  <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cpf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_wdata    (q_wdata)
   );

   cpf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .valid (q_valid),
      .level (q_level)
   );

   cpf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_rdata    (q_rdata),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .stat       (bk_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `CPF_CHECK_SAME(a_queue_bound, 1'b1, q_level <= LvlW'(QUEUE_DEPTH),
      "queue level beyond depth")
   `CPF_CHECK_SAME(a_pop_needs_room, bk_stat.pop, q_valid && (!rsp_tvalid || rsp_tready),
      "back took an item without output room")
   `CPF_CHECK_SAME(a_rsp_has_source, $rose(rsp_tvalid),
      $past(q_level != '0 || !bk_stat.idle), "result appeared without pending work")
   `CPF_CHECK_NEXT(a_idle_after_check, rsp_tvalid && rsp_tlast && rsp_tready && bk_stat.idle
      && !q_valid, bk_stat.idle, "back left idle with an empty queue")

endmodule

// ===== test/tb_configurable_packet_framer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_configurable_packet_framer_unit
// Self-checking bench for the packet framer. Header and payload items go in
// on the req_ stream. A behavioral framer with its own copy of the registers
// builds the expected wire bytes for each accepted item. Every byte taken
// from the rsp_ stream is compared with the oldest expected byte. Directed
// cases come first: field widths, check modes, empty and abandoned packets,
// and a register change inside a packet. A back-pressure burst and random
// packets under random register settings follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_configurable_packet_framer_unit;
   import cpf_pkg::*;

   localparam int          ITEM_TARGET     = 470;
   localparam int          SETTLE_CYCLES   = 48;
   localparam int          SINK_HOLD       = 300;
   localparam logic [1:0]  CHECK_UNUSED    = 2'd3;

   // head_value lands in the low bits of tdata, data_byte in the top byte
   typedef struct packed {
      logic [7:0]  data_byte;
      logic [23:0] order_value;
      logic [7:0]  payload_len;
      logic [23:0] addr_value;
      logic [23:0] head_value;
   } req_word_type;

   typedef struct {
      logic [7:0] value;
      logic       last;
   } wire_byte_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic        req_tuser;
   logic [87:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [7:0]  csr_data;

   // behavioral framer state
   logic [1:0]  field_width [4];
   logic [1:0]  check_mode_reg;
   logic [7:0]  check_value_reg;
   logic [7:0]  bytes_left;
   logic [7:0]  running_xor;
   logic        in_packet;

   wire_byte_type frame_bytes_q [$];
   int          mismatches;
   int          items_framed;
   bit          no_idle;
   bit          sink_hold;

   configurable_packet_framer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #10_000_000;
      $display("FAIL configurable_packet_framer_unit");
      $finish;
   end

   // ------------------------------------------------------------------------
   // expected wire bytes
   // ------------------------------------------------------------------------
   function automatic void emit_wire_byte(logic [7:0] value, logic last);
      wire_byte_type b;
      b.value = value;
      b.last  = last;
      frame_bytes_q.push_back(b);
      running_xor = running_xor ^ value;
   endfunction

   function automatic void close_frame(int emitted);
      wire_byte_type tail;
      case (check_mode_reg)
         CHECK_XOR:   emit_wire_byte(running_xor, 1'b1);
         CHECK_CONST: emit_wire_byte(check_value_reg, 1'b1);
         default: begin
            // no check byte: flag the last byte this item put out, if any
            if (emitted > 0) begin
               tail = frame_bytes_q.pop_back();
               tail.last = 1'b1;
               frame_bytes_q.push_back(tail);
            end
         end
      endcase
      in_packet  = 1'b0;
      bytes_left = 8'd0;
   endfunction

   task automatic frame_item(input logic kind, input req_word_type word, output bit counted);
      logic [23:0] field [4];
      logic [7:0]  len;
      int          emitted;
      emitted = 0;
      counted = 1'b1;
      if (kind == KIND_HEADER) begin
         len = word.payload_len;
         if (int'(len) > CPF_MAX_PAYLOAD) len = 8'(CPF_MAX_PAYLOAD);
         running_xor = 8'd0;
         field[FIELD_HEAD]   = word.head_value;
         field[FIELD_ADDR]   = word.addr_value;
         field[FIELD_LENGTH] = {16'd0, len};
         field[FIELD_ORDER]  = word.order_value;
         for (int f = 0; f < 4; f++) begin
            for (int i = 0; i < int'(field_width[f]); i++) begin
               emit_wire_byte(field[f][8*i +: 8], 1'b0);
               emitted++;
            end
         end
         if (len == 8'd0) begin
            close_frame(emitted);
         end else begin
            bytes_left = len;
            in_packet  = 1'b1;
         end
      end else if (!in_packet) begin
         counted = 1'b0;
      end else begin
         emit_wire_byte(word.data_byte, 1'b0);
         if (bytes_left > 8'd0) bytes_left--;
         if (bytes_left == 8'd0) close_frame(1);
      end
   endtask

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   function automatic int idle_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_word_type make_header(logic [23:0] head, logic [23:0] addr,
                                                logic [7:0] len, logic [23:0] order);
      req_word_type w;
      w.head_value  = head;
      w.addr_value  = addr;
      w.payload_len = len;
      w.order_value = order;
      w.data_byte   = 8'($urandom());
      return w;
   endfunction

   function automatic req_word_type make_payload(logic [7:0] data);
      req_word_type w;
      w = req_word_type'(88'({$urandom(), $urandom(), $urandom()}));
      w.data_byte = data;
      return w;
   endfunction

   task automatic send_item(input logic kind, input req_word_type word);
      int gap;
      bit counted;
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      frame_item(kind, word, counted);
      if (counted) items_framed++;
   endtask

   // drop the input and let everything in flight drain
   task automatic settle();
      req_tvalid <= 1'b0;
      while (frame_bytes_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // leaves csr_valid high so back-to-back writes need no gap
   task automatic csr_write(input logic [2:0] index, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_HEAD_BYTES:   field_width[FIELD_HEAD]   = value[1:0];
         CSR_ADDR_BYTES:   field_width[FIELD_ADDR]   = value[1:0];
         CSR_LENGTH_BYTES: field_width[FIELD_LENGTH] = value[1:0];
         CSR_ORDER_BYTES:  field_width[FIELD_ORDER]  = value[1:0];
         CSR_CHECK_MODE:   check_mode_reg  = value[1:0];
         CSR_CHECK_VALUE:  check_value_reg = value;
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic [7:0] head_w, input logic [7:0] addr_w,
                               input logic [7:0] length_w, input logic [7:0] order_w,
                               input logic [7:0] mode, input logic [7:0] value);
      settle();
      csr_write(CSR_HEAD_BYTES, head_w);
      csr_write(CSR_ADDR_BYTES, addr_w);
      csr_write(CSR_LENGTH_BYTES, length_w);
      csr_write(CSR_ORDER_BYTES, order_w);
      csr_write(CSR_CHECK_MODE, mode);
      csr_write(CSR_CHECK_VALUE, value);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // result sink and checker
   // ------------------------------------------------------------------------
   initial begin : rsp_sink
      int run;
      int gap;
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         if (sink_hold) begin
            rsp_tready <= 1'b0;
            repeat (SINK_HOLD) @(posedge clock);
            sink_hold = 1'b0;
         end
         rsp_tready <= 1'b1;
         run = no_idle ? 64 : $urandom_range(1, 10);
         repeat (run) @(posedge clock);
         gap = idle_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : check_wire
      wire_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (frame_bytes_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected wire byte %02h last %0b", $time, rsp_tdata,
                        rsp_tlast);
         end else begin
            want = frame_bytes_q.pop_front();
            if (rsp_tdata !== want.value || rsp_tlast !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: wire byte mismatch: expected %02h last %0b, got %02h last %0b",
                           $time, want.value, want.last, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_reset_settings();
      // no packet open yet: drop
      send_item(KIND_PAYLOAD, make_payload(8'h3C));
      send_item(KIND_HEADER, make_header(24'h123456, 24'hABCDEF, 8'd2, 24'h000102));
      send_item(KIND_PAYLOAD, make_payload(8'h00));
      send_item(KIND_PAYLOAD, make_payload(8'hFF));
   endtask

   task automatic test_wide_fields();
      apply_config(8'd3, 8'd3, 8'd3, 8'd3, 8'(CHECK_XOR), 8'h00);
      // empty payload: twelve header bytes then the check byte
      send_item(KIND_HEADER, make_header(24'hFFFFFF, 24'hFFFFFF, 8'd0, 24'hFFFFFF));
      send_item(KIND_HEADER, make_header(24'h000000, 24'h000000, 8'd1, 24'h000000));
      send_item(KIND_PAYLOAD, make_payload(8'hFF));
   endtask

   task automatic test_empty_frames();
      apply_config(8'd0, 8'd0, 8'd0, 8'd0, 8'(CHECK_NONE), 8'h00);
      // an empty header with no check byte puts nothing on the wire
      send_item(KIND_HEADER, make_header(24'hA5A5A5, 24'h5A5A5A, 8'd0, 24'hC3C3C3));
      send_item(KIND_HEADER, make_header(24'h111111, 24'h222222, 8'd1, 24'h333333));
      send_item(KIND_PAYLOAD, make_payload(8'h81));
      apply_config(8'd0, 8'd0, 8'd0, 8'd0, 8'(CHECK_CONST), 8'hFF);
      send_item(KIND_HEADER, make_header(24'h0F0F0F, 24'hF0F0F0, 8'd0, 24'h00FF00));
   endtask

   task automatic test_unused_check();
      apply_config(8'd2, 8'd1, 8'd2, 8'd3, 8'(CHECK_UNUSED), 8'hC3);
      send_item(KIND_HEADER, make_header(24'h807060, 24'h504030, 8'd2, 24'h201000));
      send_item(KIND_PAYLOAD, make_payload(8'h7E));
      send_item(KIND_PAYLOAD, make_payload(8'h01));
   endtask

   task automatic test_abandoned_packet();
      apply_config(8'd1, 8'd2, 8'd3, 8'd1, 8'(CHECK_XOR), 8'h00);
      send_item(KIND_HEADER, make_header(24'h00AA55, 24'h00CC33, 8'd255, 24'h0000F0));
      send_item(KIND_PAYLOAD, make_payload(8'h11));
      send_item(KIND_PAYLOAD, make_payload(8'h22));
      // a new header drops the open packet
      send_item(KIND_HEADER, make_header(24'h000099, 24'h004488, 8'd1, 24'h000077));
      send_item(KIND_PAYLOAD, make_payload(8'h66));
      send_item(KIND_PAYLOAD, make_payload(8'h55));
   endtask

   task automatic test_check_change_in_packet();
      apply_config(8'd1, 8'd1, 8'd1, 8'd1, 8'(CHECK_XOR), 8'h00);
      send_item(KIND_HEADER, make_header(24'h000012, 24'h000034, 8'd3, 24'h000056));
      send_item(KIND_PAYLOAD, make_payload(8'h78));
      settle();
      csr_write(CSR_CHECK_MODE, 8'(CHECK_CONST));
      csr_write(CSR_CHECK_VALUE, 8'h5A);
      csr_valid <= 1'b0;
      send_item(KIND_PAYLOAD, make_payload(8'h9A));
      send_item(KIND_PAYLOAD, make_payload(8'hBC));
   endtask

   task automatic test_backpressure();
      apply_config(8'd3, 8'd3, 8'd3, 8'd3, 8'(CHECK_XOR), 8'h00);
      no_idle   = 1'b1;
      sink_hold = 1'b1;
      repeat (3) begin
         send_item(KIND_HEADER, make_header(24'($urandom()), 24'($urandom()), 8'd4,
                                            24'($urandom())));
         repeat (4) send_item(KIND_PAYLOAD, make_payload(8'($urandom())));
      end
      no_idle = 1'b0;
   endtask

   task automatic random_config();
      logic [1:0] w [4];
      int r;
      r = $urandom_range(0, 7);
      for (int f = 0; f < 4; f++)
         w[f] = (r == 0) ? 2'd3 : (r == 1) ? 2'd0 : 2'($urandom_range(0, 3));
      apply_config({6'($urandom()), w[0]}, {6'($urandom()), w[1]},
                   {6'($urandom()), w[2]}, {6'($urandom()), w[3]},
                   {6'($urandom()), 2'($urandom_range(0, 3))}, 8'($urandom()));
      no_idle = ($urandom_range(0, 3) == 0);
   endtask

   task automatic test_random_frames();
      int frame_no;
      int r;
      int len;
      int sent;
      frame_no = 0;
      while (items_framed < ITEM_TARGET) begin
         if (frame_no % 12 == 0) random_config();
         r = $urandom_range(0, 99);
         len = $urandom_range(0, 99);
         if (frame_no == 6)  len = CPF_MAX_PAYLOAD;
         else if (len < 85)  len = $urandom_range(0, 8);
         else if (len < 98)  len = $urandom_range(9, 40);
         else                len = $urandom_range(200, 255);
         if (r < 8) begin
            repeat ($urandom_range(1, 3)) send_item(KIND_PAYLOAD, make_payload(8'($urandom())));
         end else begin
            send_item(KIND_HEADER, make_header(24'($urandom()), 24'($urandom()), 8'(len),
                                               24'($urandom())));
            sent = len;
            // cut some packets short; the next header abandons them
            if (r < 18 && len > 0) sent = $urandom_range(0, len - 1);
            for (int i = 0; i < sent; i++)
               send_item(KIND_PAYLOAD, make_payload(8'($urandom())));
         end
         frame_no++;
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = KIND_HEADER;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_HEAD_BYTES;
      csr_data   = 8'd0;
      field_width[FIELD_HEAD]   = 2'd1;
      field_width[FIELD_ADDR]   = 2'd1;
      field_width[FIELD_LENGTH] = 2'd1;
      field_width[FIELD_ORDER]  = 2'd1;
      check_mode_reg  = CHECK_NONE;
      check_value_reg = 8'd0;
      bytes_left      = 8'd0;
      running_xor     = 8'd0;
      in_packet       = 1'b0;
      mismatches      = 0;
      items_framed    = 0;
      no_idle         = 1'b0;
      sink_hold       = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_settings();
      test_wide_fields();
      test_empty_frames();
      test_unused_check();
      test_abandoned_packet();
      test_check_change_in_packet();
      test_backpressure();
      test_random_frames();

      settle();
      if (mismatches == 0 && frame_bytes_q.size() == 0) begin
         $display("PASS configurable_packet_framer_unit");
      end else begin
         $display("FAIL configurable_packet_framer_unit");
      end
      $finish;
   end

endmodule
